// ===== src/rvtiu_pkg.sv =====
// Package for the RV64 trap and interrupt unit: item and state types,
// register indexes, privilege codes and the shared trap helper functions.
// No dependencies.
package rvtiu_pkg;

  // Privilege modes
  localparam logic [1:0] PRIV_U    = 2'd0;
  localparam logic [1:0] PRIV_S    = 2'd1;
  localparam logic [1:0] PRIV_RSVD = 2'd2;
  localparam logic [1:0] PRIV_M    = 2'd3;

  // Item commands
  localparam logic CMD_RETIRE = 1'b0;
  localparam logic CMD_SET    = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] CFG_MTVEC   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STVEC   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MEDELEG = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIDELEG = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIE     = 3'd4;

  // tvec mode field
  localparam logic [1:0] TVEC_VECTORED = 2'd1;

  // mip bit positions of the external lines
  localparam logic [3:0] IRQ_MEI = 4'd11;
  localparam logic [3:0] IRQ_SEI = 4'd9;
  localparam logic [3:0] IRQ_MSI = 4'd3;
  localparam logic [3:0] IRQ_MTI = 4'd7;

  // Interrupt priority, highest first: MEI MSI MTI SEI SSI STI UEI USI UTI
  localparam int unsigned IRQ_COUNT = 9;
  localparam logic [3:0] IRQ_ORDER [IRQ_COUNT] =
    '{4'd11, 4'd3, 4'd7, 4'd9, 4'd1, 4'd5, 4'd8, 4'd0, 4'd4};

  // Status bit positions
  localparam int unsigned ST_MIE  = 0;
  localparam int unsigned ST_MPIE = 1;
  localparam int unsigned ST_MPP  = 2;
  localparam int unsigned ST_SIE  = 4;
  localparam int unsigned ST_SPIE = 5;
  localparam int unsigned ST_SPP  = 6;

  typedef struct packed {
    logic        command;
    logic        exception_valid;
    logic [3:0]  exception_cause;
    logic [63:0] exception_value;
    logic [63:0] instruction_pc;
    logic [63:0] next_pc;
    logic        pending_update;
    logic        ext_meip;
    logic        ext_seip;
    logic        ext_msip;
    logic        ext_mtip;
    logic [3:0]  status_word;
  } in_item_t;

  typedef struct packed {
    logic [63:0] resume_pc;
    logic [1:0]  privilege;
    logic        exception_taken;
    logic        exception_to_supervisor;
    logic        interrupt_taken;
    logic [3:0]  interrupt_cause;
    logic        interrupt_to_supervisor;
    logic [63:0] trap_epc;
    logic [63:0] trap_cause_word;
    logic [63:0] trap_value;
    logic [6:0]  status_bits;
    logic [11:0] pending_bits;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  priv;
    logic [6:0]  status;
    logic [11:0] pending;
  } hart_state_t;

  typedef struct packed {
    logic [63:0] mtvec;
    logic [63:0] stvec;
    logic [15:0] medeleg;
    logic [11:0] mideleg;
    logic [11:0] mie;
  } trap_cfg_t;

  typedef struct packed {
    logic       found;
    logic [3:0] cause;
  } irq_pick_t;

  // Highest-priority set bit in the fixed interrupt order
  function automatic irq_pick_t pick_irq(logic [11:0] bits);
    irq_pick_t res;
    res = '0;
    for (int i = IRQ_COUNT - 1; i >= 0; i--) begin
      if (bits[IRQ_ORDER[i]]) begin
        res.found = 1'b1;
        res.cause = IRQ_ORDER[i];
      end
    end
    return res;
  endfunction

  // Direct base, or base + 4*cause for interrupts in vectored mode
  function automatic logic [63:0] vector_target(logic [63:0] tvec, logic intr,
                                                logic [3:0] cause);
    logic [63:0] base;
    base = {tvec[63:2], 2'b00};
    if (intr && tvec[1:0] == TVEC_VECTORED) begin
      base = base + {58'd0, cause, 2'b00};
    end
    return base;
  endfunction

  // Status update on trap entry: stack xIE into xPIE, save mode into xPP
  function automatic logic [6:0] trap_status(logic [6:0] st, logic [1:0] old,
                                             logic to_s);
    logic [6:0] res;
    res = st;
    if (to_s) begin
      res[ST_SPIE] = st[ST_SIE];
      res[ST_SIE]  = 1'b0;
      res[ST_SPP]  = old[0];
    end else begin
      res[ST_MPIE]         = st[ST_MIE];
      res[ST_MIE]          = 1'b0;
      res[ST_MPP+1:ST_MPP] = old;
    end
    return res;
  endfunction

endpackage

// ===== src/rvtiu_trap_core.sv =====
// Trap decision logic for one item: pending latch, exception entry, then
// interrupt selection and entry. Purely combinational; uses rvtiu_pkg.
module rvtiu_trap_core (
  input  rvtiu_pkg::hart_state_t state,
  input  rvtiu_pkg::trap_cfg_t   cfg,
  input  rvtiu_pkg::in_item_t    item,
  output rvtiu_pkg::hart_state_t state_next,
  output rvtiu_pkg::out_item_t   result
);

  logic [11:0]           pend1;
  logic                  exc_to_s;
  logic [1:0]            priv1;
  logic [6:0]            st1;
  logic [63:0]           pc1;
  logic [11:0]           ints;
  logic [11:0]           und_ints;
  logic [11:0]           del_ints;
  rvtiu_pkg::irq_pick_t  und_pick;
  rvtiu_pkg::irq_pick_t  del_pick;
  logic                  irq_found;
  logic                  irq_to_s;
  logic [3:0]            irq_cause;

  always_comb begin
    // pending lines
    pend1 = state.pending;
    if (item.pending_update) begin
      pend1[rvtiu_pkg::IRQ_MEI] = item.ext_meip;
      pend1[rvtiu_pkg::IRQ_SEI] = item.ext_seip;
      pend1[rvtiu_pkg::IRQ_MSI] = item.ext_msip;
      pend1[rvtiu_pkg::IRQ_MTI] = item.ext_mtip;
    end

    // synchronous exception
    exc_to_s = (state.priv != rvtiu_pkg::PRIV_M) &&
               cfg.medeleg[item.exception_cause];
    if (item.exception_valid) begin
      st1   = rvtiu_pkg::trap_status(state.status, state.priv, exc_to_s);
      priv1 = exc_to_s ? rvtiu_pkg::PRIV_S : rvtiu_pkg::PRIV_M;
      pc1   = rvtiu_pkg::vector_target(exc_to_s ? cfg.stvec : cfg.mtvec, 1'b0,
                                       item.exception_cause);
    end else begin
      st1   = state.status;
      priv1 = state.priv;
      pc1   = item.next_pc;
    end

    // interrupt choice on the post-exception mode and status
    ints     = pend1 & cfg.mie;
    und_ints = ints & ~cfg.mideleg;
    del_ints = ints & cfg.mideleg;
    und_pick = rvtiu_pkg::pick_irq(und_ints);
    del_pick = rvtiu_pkg::pick_irq(del_ints);
    irq_found = 1'b0;
    irq_to_s  = 1'b0;
    irq_cause = und_pick.cause;
    if (priv1 == rvtiu_pkg::PRIV_M) begin
      irq_found = st1[rvtiu_pkg::ST_MIE] && und_pick.found;
    end else if (und_pick.found) begin
      irq_found = 1'b1;
    end else if (priv1 == rvtiu_pkg::PRIV_U || st1[rvtiu_pkg::ST_SIE]) begin
      irq_found = del_pick.found;
      irq_to_s  = del_pick.found;
      irq_cause = del_pick.cause;
    end
  end

  always_comb begin
    state_next = state;
    result     = '0;
    result.resume_pc = item.next_pc;
    if (item.command == rvtiu_pkg::CMD_SET) begin
      if (item.status_word[1:0] != rvtiu_pkg::PRIV_RSVD) begin
        state_next.priv = item.status_word[1:0];
      end
      state_next.status[rvtiu_pkg::ST_MIE] = item.status_word[2];
      state_next.status[rvtiu_pkg::ST_SIE] = item.status_word[3];
    end else begin
      state_next.priv    = priv1;
      state_next.status  = st1;
      state_next.pending = pend1;
      result.resume_pc   = pc1;
      if (item.exception_valid) begin
        result.exception_taken         = 1'b1;
        result.exception_to_supervisor = exc_to_s;
        result.trap_epc                = item.instruction_pc;
        result.trap_cause_word         = {60'd0, item.exception_cause};
        result.trap_value              = item.exception_value;
      end
      if (irq_found) begin
        state_next.priv   = irq_to_s ? rvtiu_pkg::PRIV_S : rvtiu_pkg::PRIV_M;
        state_next.status = rvtiu_pkg::trap_status(st1, priv1, irq_to_s);
        state_next.pending[irq_cause] = 1'b0;
        result.resume_pc  = rvtiu_pkg::vector_target(
                              irq_to_s ? cfg.stvec : cfg.mtvec, 1'b1, irq_cause);
        result.interrupt_taken         = 1'b1;
        result.interrupt_cause         = irq_cause;
        result.interrupt_to_supervisor = irq_to_s;
        // interrupt epc/tval is the pc after any exception entry this step
        result.trap_epc                = pc1;
        result.trap_cause_word         = {1'b1, 59'd0, irq_cause};
        result.trap_value              = pc1;
      end
    end
    result.privilege    = state_next.priv;
    result.status_bits  = state_next.status;
    result.pending_bits = state_next.pending;
  end

endmodule

// ===== src/riscv_trap_interrupt_unit.sv =====
// Top level of the RV64 trap and interrupt unit: input register, hart state,
// configuration registers, output register. Uses rvtiu_pkg, rvtiu_trap_core.
// Items pass from the input register to the output register at 1 item/cycle
// while the result is not stalled. A stalled result holds the input register.
// The combinational decode path between input and output register sets the rate;
// hart state updates as an item moves into the output register.
// Reset (sync, active high): machine mode, status/pending/config cleared.
module riscv_trap_interrupt_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  rvtiu_pkg::in_item_t                   in_item,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output rvtiu_pkg::out_item_t                  out_item,
  input  logic                                  cfg_write,
  input  logic [rvtiu_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [63:0]                           cfg_data
);

  rvtiu_pkg::in_item_t    s1_item;
  logic                   s1_valid;
  logic                   s1_fire;
  rvtiu_pkg::hart_state_t hart;
  rvtiu_pkg::hart_state_t hart_next;
  rvtiu_pkg::trap_cfg_t   cfg;
  rvtiu_pkg::out_item_t   result;

  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rvtiu_pkg::CFG_MTVEC:   cfg.mtvec   <= cfg_data;
        rvtiu_pkg::CFG_STVEC:   cfg.stvec   <= cfg_data;
        rvtiu_pkg::CFG_MEDELEG: cfg.medeleg <= cfg_data[15:0];
        rvtiu_pkg::CFG_MIDELEG: cfg.mideleg <= cfg_data[11:0];
        rvtiu_pkg::CFG_MIE:     cfg.mie     <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  rvtiu_trap_core u_core (
    .state      (hart),
    .cfg        (cfg),
    .item       (s1_item),
    .state_next (hart_next),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hart.priv    <= rvtiu_pkg::PRIV_M;
      hart.status  <= '0;
      hart.pending <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (s1_fire) begin
        hart <= hart_next;
      end
      if (s1_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (s1_fire) begin
      out_item <= result;
    end
  end

  // the reserved mode code never becomes current
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.privilege != rvtiu_pkg::PRIV_RSVD)
    else $error("reserved privilege reported");

  // a taken interrupt has its pending bit cleared in the same result
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.interrupt_taken |->
      ((out_item.pending_bits >> out_item.interrupt_cause) & 12'd1) == 12'd0)
    else $error("taken interrupt still pending");

  // exception delegated to S ends in S mode unless an interrupt follows
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.exception_to_supervisor && !out_item.interrupt_taken |->
      out_item.privilege == rvtiu_pkg::PRIV_S)
    else $error("delegated exception not in S mode");

  // hart state only moves when an item is processed
  assert property (@(posedge clk) disable iff (rst)
    !s1_fire |=> $stable(hart))
    else $error("hart state changed without an item");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for riscv_trap_interrupt_unit: directed trap and interrupt cases,
// then random retire/set traffic under varying handshake pressure and trap configurations.
// Depends on rvtiu_pkg and the unit itself.
module tb_top;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  rvtiu_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rvtiu_pkg::out_item_t out_item;
  logic cfg_write = 1'b0;
  logic [rvtiu_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  riscv_trap_interrupt_unit uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // interrupt priority, highest first: MEI MSI MTI SEI SSI STI UEI USI UTI
  localparam logic [35:0] IRQ_RANK = {4'd11, 4'd3, 4'd7, 4'd9, 4'd1, 4'd5, 4'd8, 4'd0, 4'd4};
  localparam int unsigned DRAIN_LIMIT = 20000;

  // shadow hart state and trap configuration
  logic [1:0]  hart_priv = rvtiu_pkg::PRIV_M;
  logic [6:0]  hart_status = '0;
  logic [11:0] hart_pending = '0;
  rvtiu_pkg::trap_cfg_t cur_cfg = '0;

  rvtiu_pkg::out_item_t step_results_q[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_count = 0;
  int results_seen = 0;
  int items_sent = 0;
  int set_cmds = 0;
  int exc_traps = 0;
  int exc_to_s = 0;
  int irq_traps = 0;
  int irq_to_s = 0;
  int cfg_settings = 0;
  bit drain_timeout = 1'b0;

  function automatic logic top_irq(input logic [11:0] bits, output logic [3:0] cause);
    logic hit;
    logic [3:0] c;
    hit = 1'b0;
    cause = '0;
    for (int k = 0; k < 9; k++) begin
      c = IRQ_RANK[35 - 4*k -: 4];
      if (!hit && bits[c]) begin
        hit = 1'b1;
        cause = c;
      end
    end
    return hit;
  endfunction

  // stack the enables, switch mode, return the handler address
  function automatic logic [63:0] enter_trap(input logic intr, input logic [3:0] cause,
                                             input logic to_s);
    logic [63:0] tvec;
    logic [63:0] target;
    if (to_s) begin
      hart_status[rvtiu_pkg::ST_SPIE] = hart_status[rvtiu_pkg::ST_SIE];
      hart_status[rvtiu_pkg::ST_SIE]  = 1'b0;
      hart_status[rvtiu_pkg::ST_SPP]  = hart_priv[0];
      hart_priv = rvtiu_pkg::PRIV_S;
      tvec = cur_cfg.stvec;
    end else begin
      hart_status[rvtiu_pkg::ST_MPIE]     = hart_status[rvtiu_pkg::ST_MIE];
      hart_status[rvtiu_pkg::ST_MIE]      = 1'b0;
      hart_status[rvtiu_pkg::ST_MPP +: 2] = hart_priv;
      hart_priv = rvtiu_pkg::PRIV_M;
      tvec = cur_cfg.mtvec;
    end
    target = {tvec[63:2], 2'b00};
    if (intr && tvec[1:0] == rvtiu_pkg::TVEC_VECTORED) begin
      target = target + {58'd0, cause, 2'b00};
    end
    return target;
  endfunction

  function automatic rvtiu_pkg::out_item_t predict_hart_step(input rvtiu_pkg::in_item_t it);
    rvtiu_pkg::out_item_t r;
    logic [63:0] pc;
    logic [63:0] here;
    logic [11:0] live;
    logic [3:0] cause;
    logic hit;
    logic to_s;
    r = '0;
    pc = it.next_pc;
    hit = 1'b0;
    to_s = 1'b0;
    cause = '0;
    if (it.command == rvtiu_pkg::CMD_SET) begin
      set_cmds++;
      if (it.status_word[1:0] != rvtiu_pkg::PRIV_RSVD) begin
        hart_priv = it.status_word[1:0];
      end
      hart_status[rvtiu_pkg::ST_MIE] = it.status_word[2];
      hart_status[rvtiu_pkg::ST_SIE] = it.status_word[3];
    end else begin
      if (it.pending_update) begin
        hart_pending[rvtiu_pkg::IRQ_MEI] = it.ext_meip;
        hart_pending[rvtiu_pkg::IRQ_SEI] = it.ext_seip;
        hart_pending[rvtiu_pkg::IRQ_MSI] = it.ext_msip;
        hart_pending[rvtiu_pkg::IRQ_MTI] = it.ext_mtip;
      end
      if (it.exception_valid) begin
        r.exception_taken = 1'b1;
        r.exception_to_supervisor = (hart_priv != rvtiu_pkg::PRIV_M) &&
                                    cur_cfg.medeleg[it.exception_cause];
        pc = enter_trap(1'b0, it.exception_cause, r.exception_to_supervisor);
        r.trap_epc = it.instruction_pc;
        r.trap_cause_word = {60'd0, it.exception_cause};
        r.trap_value = it.exception_value;
        exc_traps++;
        if (r.exception_to_supervisor) exc_to_s++;
      end
      // mode is the one left by any exception trap above
      live = hart_pending & cur_cfg.mie;
      if (hart_priv == rvtiu_pkg::PRIV_M) begin
        if (hart_status[rvtiu_pkg::ST_MIE]) hit = top_irq(live & ~cur_cfg.mideleg, cause);
      end else begin
        hit = top_irq(live & ~cur_cfg.mideleg, cause);
        if (!hit && (hart_priv == rvtiu_pkg::PRIV_U || hart_status[rvtiu_pkg::ST_SIE])) begin
          hit = top_irq(live & cur_cfg.mideleg, cause);
          to_s = hit;
        end
      end
      if (hit) begin
        here = pc;
        r.interrupt_taken = 1'b1;
        r.interrupt_cause = cause;
        r.interrupt_to_supervisor = to_s;
        pc = enter_trap(1'b1, cause, to_s);
        r.trap_epc = here;
        r.trap_cause_word = {1'b1, 59'd0, cause};
        r.trap_value = here;
        hart_pending[cause] = 1'b0;
        irq_traps++;
        if (to_s) irq_to_s++;
      end
    end
    r.resume_pc = pc;
    r.privilege = hart_priv;
    r.status_bits = hart_status;
    r.pending_bits = hart_pending;
    return r;
  endfunction

  function automatic logic [63:0] rand_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic rvtiu_pkg::in_item_t make_retire(input logic exc, input logic [3:0] cause,
                                                      input logic upd, input logic [3:0] lines);
    rvtiu_pkg::in_item_t it;
    it.command = rvtiu_pkg::CMD_RETIRE;
    it.exception_valid = exc;
    it.exception_cause = cause;
    it.exception_value = rand_word();
    it.instruction_pc = rand_word();
    it.next_pc = rand_word();
    it.pending_update = upd;
    {it.ext_meip, it.ext_seip, it.ext_msip, it.ext_mtip} = lines;
    it.status_word = 4'($urandom);
    return it;
  endfunction

  // set command: everything but the status word is noise
  function automatic rvtiu_pkg::in_item_t make_set(input logic [3:0] sw);
    rvtiu_pkg::in_item_t it;
    it = make_retire(1'($urandom), 4'($urandom), 1'($urandom), 4'($urandom));
    it.command = rvtiu_pkg::CMD_SET;
    it.status_word = sw;
    return it;
  endfunction

  function automatic rvtiu_pkg::in_item_t random_item();
    rvtiu_pkg::in_item_t it;
    it = make_retire($urandom_range(99) < 35, 4'($urandom), $urandom_range(99) < 30,
                     4'($urandom));
    if ($urandom_range(99) < 15) it.command = rvtiu_pkg::CMD_SET;
    return it;
  endfunction

  function automatic rvtiu_pkg::trap_cfg_t random_cfg();
    rvtiu_pkg::trap_cfg_t c;
    c.mtvec = rand_word();
    c.stvec = rand_word();
    if ($urandom_range(1)) c.mtvec[1:0] = rvtiu_pkg::TVEC_VECTORED;
    if ($urandom_range(1)) c.stvec[1:0] = rvtiu_pkg::TVEC_VECTORED;
    c.medeleg = 16'(rand_word());
    c.mideleg = 12'(rand_word());
    c.mie = 12'(rand_word());
    return c;
  endfunction

  task automatic send_item(input rvtiu_pkg::in_item_t it);
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    step_results_q.push_back(predict_hart_step(it));
    items_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic wait_idle();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (step_results_q.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (guard >= DRAIN_LIMIT) drain_timeout = 1'b1;
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_config(input rvtiu_pkg::trap_cfg_t c);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    cfg_write <= 1'b1;
    cfg_index <= rvtiu_pkg::CFG_MTVEC;
    cfg_data <= c.mtvec;
    @(posedge clk);
    cfg_index <= rvtiu_pkg::CFG_STVEC;
    cfg_data <= c.stvec;
    @(posedge clk);
    // junk above the register width must be dropped
    cfg_index <= rvtiu_pkg::CFG_MEDELEG;
    cfg_data <= {junk[63:16], c.medeleg};
    @(posedge clk);
    cfg_index <= rvtiu_pkg::CFG_MIDELEG;
    cfg_data <= {junk[63:12], c.mideleg};
    @(posedge clk);
    cfg_index <= rvtiu_pkg::CFG_MIE;
    cfg_data <= {junk[63:12], c.mie};
    @(posedge clk);
    // unmapped index: no register may change
    if ($urandom_range(1)) begin
      cfg_index <= rvtiu_pkg::CFG_MIE + 3'($urandom_range(3, 1));
      cfg_data <= junk;
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    cur_cfg = c;
    cfg_settings++;
  endtask

  function automatic void check_field(input string fname, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("result %0d: %s expected %h got %h", results_seen, fname, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    rvtiu_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (step_results_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result %0d arrived with nothing expected: %h", results_seen, out_item);
      end else begin
        want = step_results_q.pop_front();
        check_field("resume_pc", want.resume_pc, out_item.resume_pc);
        check_field("privilege", 64'(want.privilege), 64'(out_item.privilege));
        check_field("exception_taken", 64'(want.exception_taken),
                    64'(out_item.exception_taken));
        check_field("exception_to_supervisor", 64'(want.exception_to_supervisor),
                    64'(out_item.exception_to_supervisor));
        check_field("interrupt_taken", 64'(want.interrupt_taken),
                    64'(out_item.interrupt_taken));
        check_field("interrupt_cause", 64'(want.interrupt_cause),
                    64'(out_item.interrupt_cause));
        check_field("interrupt_to_supervisor", 64'(want.interrupt_to_supervisor),
                    64'(out_item.interrupt_to_supervisor));
        check_field("trap_epc", want.trap_epc, out_item.trap_epc);
        check_field("trap_cause_word", want.trap_cause_word, out_item.trap_cause_word);
        check_field("trap_value", want.trap_value, out_item.trap_value);
        check_field("status_bits", 64'(want.status_bits), 64'(out_item.status_bits));
        check_field("pending_bits", 64'(want.pending_bits), 64'(out_item.pending_bits));
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // registers still at reset: everything goes to address zero, nothing enabled
  task automatic test_reset_state();
    send_item(make_retire(1'b0, 4'd0, 1'b0, 4'b0000));
    send_item(make_retire(1'b1, 4'd2, 1'b1, 4'b1111));
    wait_idle();
  endtask

  task automatic test_directed_traps();
    rvtiu_pkg::trap_cfg_t c;
    rvtiu_pkg::in_item_t it;
    c.mtvec = 64'hFFFF_FFFF_FFFF_FFFD;   // vectored, top base: handler address wraps
    c.stvec = 64'h0000_0000_8000_0101;
    c.medeleg = '1;
    c.mideleg = 12'h222;                 // SSI, STI, SEI delegated
    c.mie = '1;
    apply_config(c);
    // M mode ignores medeleg
    it = make_retire(1'b1, 4'd15, 1'b0, 4'b0000);
    it.instruction_pc = '1;
    it.exception_value = '1;
    it.next_pc = '1;
    send_item(it);
    it = make_retire(1'b1, 4'd0, 1'b0, 4'b0000);
    it.instruction_pc = '0;
    it.exception_value = '0;
    it.next_pc = '0;
    send_item(it);
    send_item(make_set({1'b0, 1'b0, rvtiu_pkg::PRIV_S}));
    // undelegated interrupts fire in S regardless of enables
    send_item(make_retire(1'b0, 4'd0, 1'b0, 4'b0000));
    send_item(make_set({1'b1, 1'b0, rvtiu_pkg::PRIV_U}));
    // delegated exception from U, then undelegated interrupt in the same step
    send_item(make_retire(1'b1, 4'd5, 1'b0, 4'b0000));
    send_item(make_set({1'b1, 1'b1, rvtiu_pkg::PRIV_M}));
    send_item(make_retire(1'b0, 4'd0, 1'b0, 4'b0000));
    send_item(make_retire(1'b0, 4'd0, 1'b0, 4'b0000));
    send_item(make_set({1'b1, 1'b0, rvtiu_pkg::PRIV_S}));
    send_item(make_retire(1'b0, 4'd0, 1'b0, 4'b0000));
    // reserved privilege keeps the mode, still writes the enables
    send_item(make_set({1'b0, 1'b0, rvtiu_pkg::PRIV_RSVD}));
    send_item(make_set({1'b1, 1'b1, rvtiu_pkg::PRIV_RSVD}));
    send_item(make_retire(1'b0, 4'd0, 1'b1, 4'b1111));
    send_item(make_retire(1'b1, 4'd9, 1'b1, 4'b0000));
    wait_idle();
    c.mtvec = 64'h0000_0000_0000_1000;
    c.stvec = 64'hFFFF_FFFF_FFFF_FFFF;   // mode 3 acts as direct
    c.mideleg = '1;
    c.medeleg = 16'h8000;
    apply_config(c);
    send_item(make_set({1'b0, 1'b0, rvtiu_pkg::PRIV_U}));
    send_item(make_retire(1'b0, 4'd0, 1'b1, 4'b0100));
    send_item(make_set({1'b0, 1'b0, rvtiu_pkg::PRIV_U}));
    send_item(make_retire(1'b1, 4'd15, 1'b1, 4'b1011));
    send_item(make_set({1'b1, 1'b1, rvtiu_pkg::PRIV_M}));
    send_item(make_retire(1'b1, 4'd14, 1'b1, 4'b0000));
    wait_idle();
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n_items);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < n_items; i++) begin
      if (i % 146 == 0) begin
        wait_idle();
        apply_config(random_cfg());
      end
      send_item(random_item());
    end
    wait_idle();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 26;
    recv_idle_pct = 84;
    test_reset_state();
    test_directed_traps();
    test_random_traffic(26, 84, 584);
    test_random_traffic(84, 26, 583);
    test_random_traffic(0, 0, 583);
    wait_idle();
    $display("Sent %0d items (%0d set commands) over %0d trap configurations, %0d results",
             items_sent, set_cmds, cfg_settings, results_seen);
    $display("Exception traps %0d (%0d to S), interrupt traps %0d (%0d to S), mismatches %0d",
             exc_traps, exc_to_s, irq_traps, irq_to_s, mismatch_count);
    if (step_results_q.size() != 0)
      $display("%0d expected results never arrived", step_results_q.size());
    if (mismatch_count == 0 && !drain_timeout && step_results_q.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #3_600_000;
    $display("Timed out waiting for the unit");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
